>>> src/deq_pkg.sv
// Shared definitions for the double-ended queue: operation and status codes,
// default sizes and the control word that steers the cell row.
// Depends on nothing.
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    localparam logic [ST_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;

    // One-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic ins_head;
        logic ins_tail;
        logic rem_head;
        logic rem_tail;
    } t_cell_ctrl;

endpackage

>>> src/deq_cell.sv
// One storage cell of the queue row: a word and its occupied flag.
// Depends on deq_pkg for the row control word.
module deq_cell
    import deq_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [WORD_WIDTH-1:0] i_push_value,
    input  logic [WORD_WIDTH-1:0] i_left_data,
    input  logic                  i_left_valid,
    input  logic [WORD_WIDTH-1:0] i_right_data,
    input  logic                  i_right_valid,
    output logic [WORD_WIDTH-1:0] o_data,
    output logic                  o_valid
);

    logic [WORD_WIDTH-1:0] r_data;
    logic                  r_valid;

    // Occupied flags form a thermometer, so the first free cell is the one
    // whose left neighbor is occupied while it is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.ins_head) begin
            r_valid <= i_left_valid;
        end else if (i_ctrl.ins_tail) begin
            if (i_left_valid) begin
                r_valid <= 1'b1;
            end
        end else if (i_ctrl.rem_head) begin
            r_valid <= i_right_valid;
        end else if (i_ctrl.rem_tail) begin
            if (!i_right_valid) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_head) begin
            r_data <= i_left_data;
        end else if (i_ctrl.ins_tail && i_left_valid && !r_valid) begin
            r_data <= i_push_value;
        end else if (i_ctrl.rem_head) begin
            r_data <= i_right_data;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

>>> src/double_ended_queue_top.sv
// Top level of the double-ended queue: handshake control, the row of
// storage cells and the result registers.
// Depends on deq_pkg and deq_cell.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      i_op, i_value
//  result    out        o_out_valid / i_out_ready    o_status, o_entry_total,
//                                                    o_front_value, o_back_value,
//                                                    o_front_next_value,
//                                                    o_second_last_value
//
// The cell row shifts at the accept edge, and in the cycle after, the ends
// of the row are read into the result registers. The back
// end is found through a one-hot select across all DEPTH cells.
// Reset clears the occupied flags, the count and the control state; stored
// words are never read before a push writes them.
// A new item is taken in the same cycle the pending result leaves, so a
// stalled result holds the input side off.
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_W-1:0]        o_entry_total,
    output logic signed [VAL_W-1:0] o_front_value,
    output logic signed [VAL_W-1:0] o_back_value,
    output logic signed [VAL_W-1:0] o_front_next_value,
    output logic signed [VAL_W-1:0] o_second_last_value
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]      r_count;
    logic [ST_W-1:0]       r_status;
    logic [VAL_W-1:0]      r_front, r_back, r_next_front, r_prev_back;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic [ST_W-1:0]       w_status;
    t_cell_ctrl            w_ctrl;
    logic [WORD_WIDTH-1:0] w_push;

    logic [WORD_WIDTH-1:0] w_data  [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_last;
    logic [WORD_WIDTH-1:0] w_back_word, w_second_word;

    // The input side opens when nothing is pending, or when the pending
    // result is being taken in this very cycle.
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_SHOW) && i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_push     = WORD_WIDTH'(i_value);

    // Words fill the row from cell zero, so the front sits in cell zero and
    // the row is full when the far cell is occupied.
    assign w_full  = w_valid[DEPTH-1];
    assign w_empty = !w_valid[0];

    always_comb begin
        w_ctrl   = '0;
        w_status = STAT_DONE;
        case (i_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_ctrl.ins_head = w_accept && (i_op == OP_PUSH_FRONT);
                    w_ctrl.ins_tail = w_accept && (i_op == OP_PUSH_BACK);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                end else begin
                    w_ctrl.rem_head = w_accept && (i_op == OP_POP_FRONT);
                    w_ctrl.rem_tail = w_accept && (i_op == OP_POP_BACK);
                end
            end
            default: begin
                // Query and the unused codes leave the queue alone.
                w_status = STAT_DONE;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_left_data, w_right_data;
        logic                  w_left_valid, w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_data  = w_push;
            assign w_left_valid = 1'b1;
        end else begin : g_mid
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        deq_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_push_value  (w_push),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g])
        );

        // The back word is the last occupied cell of the thermometer.
        if (g == DEPTH - 1) begin : g_last_tail
            assign w_last[g] = w_valid[g];
        end else begin : g_last_inner
            assign w_last[g] = w_valid[g] && !w_valid[g+1];
        end
    end

    // The second-to-last word sits just before the last occupied cell; both
    // selects are one-hot or empty, so an OR across the row picks the word.
    always_comb begin
        w_back_word   = '0;
        w_second_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_word = w_back_word | (w_data[i] & {WORD_WIDTH{w_last[i]}});
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            w_second_word = w_second_word | (w_data[i] & {WORD_WIDTH{w_last[i+1]}});
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end else if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.ins_head || w_ctrl.ins_tail) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_ctrl.rem_head || w_ctrl.rem_tail) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Result words are captured once the row has settled after the shift.
    // Each word is sign-extended from the storage width to the port width.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
        end
        if (r_state == S_EVAL) begin
            r_front      <= w_valid[0] ? VAL_W'(signed'(w_data[0])) : '0;
            r_next_front <= w_valid[1] ? VAL_W'(signed'(w_data[1])) : '0;
            r_back       <= VAL_W'(signed'(w_back_word));
            r_prev_back  <= VAL_W'(signed'(w_second_word));
        end
    end

    assign o_out_valid         = (r_state == S_SHOW);
    assign o_status            = r_status;
    assign o_entry_total       = r_count;
    assign o_front_value       = r_front;
    assign o_back_value        = r_back;
    assign o_front_next_value  = r_next_front;
    assign o_second_last_value = r_prev_back;

endmodule

>>> test/double_ended_queue_top_tb.sv
// Self-checking testbench for the double-ended queue top level.
// A queue-based predictor runs beside the block and every result is checked.
// Depends on deq_pkg and double_ended_queue_top.
module double_ended_queue_top_tb
    import deq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W      = $clog2(DEPTH_DEF + 1);
    localparam int MAX_GAP    = 12;   // longest sender pause, in cycles
    localparam int MAX_STALL  = 16;   // longest receiver stall, in cycles
    localparam int IDLE_LIMIT = 500;  // cycles without any transfer before giving up
    localparam int MAX_PRINTS = 20;   // mismatch lines printed before going quiet

    // Op codes 5 to 7 are not defined; the block must treat them as a query.
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    // One result item as the block should produce it.
    typedef struct {
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        total;
        logic signed [VAL_W-1:0] front;
        logic signed [VAL_W-1:0] back;
        logic signed [VAL_W-1:0] next_front;
        logic signed [VAL_W-1:0] prev_back;
    } t_deq_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_op = OP_QUERY;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [ST_W-1:0]         o_status;
    logic [CNT_W-1:0]        o_entry_total;
    logic signed [VAL_W-1:0] o_front_value;
    logic signed [VAL_W-1:0] o_back_value;
    logic signed [VAL_W-1:0] o_front_next_value;
    logic signed [VAL_W-1:0] o_second_last_value;

    // The predictor keeps the stored words in order, front first.
    logic signed [VAL_W-1:0] deque_words[$];
    // Results predicted for accepted items and not yet seen at the output.
    t_deq_result             pending_results[$];

    int  mismatch_count = 0;
    int  checked_count  = 0;
    int  push_count     = 0;
    int  pop_count      = 0;
    int  query_count    = 0;
    int  full_refusals  = 0;
    int  empty_refusals = 0;
    int  burst_left     = 0;
    int  gap_pct        = 30;   // chance of a pause when a burst ends
    bit  in_driven      = 1'b0; // mirrors the value last scheduled on i_in_valid

    double_ended_queue_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_value             (i_value),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_entry_total       (o_entry_total),
        .o_front_value       (o_front_value),
        .o_back_value        (o_back_value),
        .o_front_next_value  (o_front_next_value),
        .o_second_last_value (o_second_last_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation to the predicted queue and returns the result the
    // block must give for it. Refused pushes and pops leave the queue as it is.
    function automatic t_deq_result apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic signed [VAL_W-1:0] value);
        t_deq_result r;
        int          n;
        r.status = STAT_DONE;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (deque_words.size() >= DEPTH_DEF) begin
                    r.status = STAT_FULL;
                    full_refusals++;
                end else if (op == OP_PUSH_FRONT) begin
                    deque_words.insert(0, value);
                end else begin
                    deque_words.insert(deque_words.size(), value);
                end
                push_count++;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (deque_words.size() == 0) begin
                    r.status = STAT_EMPTY;
                    empty_refusals++;
                end else if (op == OP_POP_FRONT) begin
                    deque_words.delete(0);
                end else begin
                    deque_words.delete(deque_words.size() - 1);
                end
                pop_count++;
            end
            default: begin
                // Query and every undefined code only report the state.
                query_count++;
            end
        endcase
        n = deque_words.size();
        r.total      = CNT_W'(n);
        r.front      = (n >= 1) ? deque_words[0]     : '0;
        r.back       = (n >= 1) ? deque_words[n - 1] : '0;
        r.next_front = (n >= 2) ? deque_words[1]     : '0;
        r.prev_back  = (n >= 2) ? deque_words[n - 2] : '0;
        return r;
    endfunction

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string field, input int expected_val,
                                   input int actual_val);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH on result %0d, %s: expected %0d, got %0d",
                     $realtime, checked_count, field, expected_val, actual_val);
        end
    endtask

    // Offers one item on the input channel and waits until it is taken. The
    // sender works in bursts; when a burst runs out it may drop valid for a
    // random number of cycles before the next item.
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic signed [VAL_W-1:0] value);
        if (burst_left == 0) begin
            if (in_driven && $urandom_range(0, 99) < gap_pct) begin
                i_in_valid <= 1'b0;
                in_driven = 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        in_driven = 1'b1;
        i_op      <= op;
        i_value   <= value;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        pending_results.insert(pending_results.size(), apply_deque_op(op, value));
    endtask

    // Holds the sender off until every predicted result has arrived.
    task automatic wait_for_results();
        if (in_driven) begin
            i_in_valid <= 1'b0;
            in_driven = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly random words, with the extremes and small values mixed in often
    // so that sign and carry corners keep turning up.
    function automatic logic signed [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(VAL_W - 1){1'b0}}};
            1:       return {1'b0, {(VAL_W - 1){1'b1}}};
            2:       return '1;
            3:       return '0;
            4:       return VAL_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_undef_op();
        return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    endfunction

    // Draws an operation with the given push and pop percentages; the rest is
    // queries, with a share of undefined codes.
    function automatic logic [OP_W-1:0] pick_op(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else if (r < push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        end else if ($urandom_range(0, 3) == 0) begin
            return pick_undef_op();
        end
        return OP_QUERY;
    endfunction

    task automatic run_random(input int count, input int push_pct, input int pop_pct);
        for (int k = 0; k < count; k++) begin
            send_item(pick_op(push_pct, pop_pct), pick_word());
        end
    endtask

    // An empty queue: queries, pops on both ends, and undefined codes.
    task automatic test_empty_queue();
        send_item(OP_QUERY, pick_word());
        send_item(OP_POP_FRONT, pick_word());
        send_item(OP_POP_BACK, pick_word());
        send_item(OP_UNDEF_LO, pick_word());
        send_item(OP_UNDEF_HI, pick_word());
    endtask

    // Extreme words at both ends, then pops down through one word to empty and one more pop on empty.
    task automatic test_word_extremes();
        send_item(OP_PUSH_BACK, {1'b0, {(VAL_W - 1){1'b1}}});
        send_item(OP_PUSH_FRONT, {1'b1, {(VAL_W - 1){1'b0}}});
        send_item(OP_PUSH_BACK, '1);
        send_item(OP_PUSH_FRONT, '0);
        send_item(OP_PUSH_BACK, 32'sd1);
        send_item(OP_QUERY, pick_word());
        send_item(OP_POP_FRONT, pick_word());
        send_item(OP_POP_BACK, pick_word());
        send_item(OP_POP_BACK, pick_word());
        send_item(OP_POP_FRONT, pick_word());
        send_item(OP_POP_FRONT, pick_word());
        send_item(OP_POP_BACK, pick_word());
        wait_for_results();
    endtask

    // Even mix of pushes and pops; the count wanders and words shift through the row.
    task automatic test_balanced_traffic();
        gap_pct = 30;
        run_random(500, 40, 40);
        wait_for_results();
    endtask

    // Push-heavy traffic keeps the queue at or near full, so pushes on a full
    // queue are refused again and again. The sender stops halfway to let the
    // block drain its pending results.
    task automatic test_fill_to_full();
        gap_pct = 50;
        run_random(175, 75, 15);
        wait_for_results();
        run_random(175, 75, 15);
        wait_for_results();
    endtask

    // Pop-heavy traffic empties the queue and then hits pops on empty.
    task automatic test_drain_to_empty();
        gap_pct = 40;
        run_random(350, 15, 70);
        wait_for_results();
    endtask

    // No sender pauses at all: items go in as fast as the block takes them.
    task automatic test_back_to_back();
        gap_pct = 0;
        run_random(400, 45, 40);
        wait_for_results();
    endtask

    // Receiver: switches between always ready, random stalls and long on/off
    // runs, each for a random stretch of cycles.
    initial begin : receiver
        int seg_left;
        int run_left;
        int mode;
        bit rdy;
        seg_left = 0;
        run_left = 0;
        mode     = 0;
        rdy      = 1'b1;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 9) < 7);
                default: begin
                    if (run_left == 0) begin
                        rdy      = !rdy;
                        run_left = $urandom_range(1, MAX_STALL);
                    end
                    run_left--;
                end
            endcase
            i_out_ready <= rdy;
        end
    end

    // Checker: every result taken from the block is compared with the oldest
    // prediction. Values are read at the edge, before any update of that edge.
    always @(posedge i_clk) begin
        t_deq_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            checked_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_entry_total !== want.total)
                    report_mismatch("entry_total", want.total, o_entry_total);
                if (o_front_value !== want.front)
                    report_mismatch("front_value", want.front, o_front_value);
                if (o_back_value !== want.back)
                    report_mismatch("back_value", want.back, o_back_value);
                if (o_front_next_value !== want.next_front)
                    report_mismatch("front_next_value", want.next_front,
                                    o_front_next_value);
                if (o_second_last_value !== want.prev_back)
                    report_mismatch("second_last_value", want.prev_back,
                                    o_second_last_value);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] Timeout: no item moved for %0d cycles, %0d results pending",
                         $realtime, IDLE_LIMIT, pending_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : main
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_word_extremes();
        test_balanced_traffic();
        test_fill_to_full();
        test_drain_to_empty();
        test_back_to_back();

        // All results are in; give the block time to show any stray result.
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_results.size());
        end

        $display("Checked %0d results: %0d pushes (%0d refused as full), %0d pops",
                 checked_count, push_count, full_refusals, pop_count);
        $display("(%0d refused as empty), %0d queries or undefined codes; %0d mismatches.",
                 empty_refusals, query_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue_top.sv
test/double_ended_queue_top_tb.sv
